### hw/rtl/jcba_pkg.sv
// ----------------------------------------------------------------------------
// jcba_pkg
// Shared types and codes for the journaled contiguous block allocator.
// ----------------------------------------------------------------------------
package jcba_pkg;

  // Fixed field widths of the transaction payloads
  localparam int LEN_W   = 13;
  localparam int DESC_W  = 4;
  localparam int START_W = 6;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_REPAIR = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DESC  = 3'd1,
    ST_UNUSED    = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NO_DESC   = 3'd4
  } status_e;

  // Simulated crash points of a write
  localparam logic [2:0] CRASH_AFTER_JRNL     = 3'd1;
  localparam logic [2:0] CRASH_AFTER_JRNL_ALT = 3'd2;
  localparam logic [2:0] CRASH_AFTER_FREE     = 3'd3;
  localparam logic [2:0] CRASH_AFTER_MOVE     = 3'd4;

  typedef struct packed {
    action_e             action;
    logic [DESC_W-1:0]   descriptor;
    logic [LEN_W-1:0]    byte_length;
    logic [2:0]          crash_stage;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [DESC_W-1:0]   created_descriptor;
    logic [START_W-1:0]  start_block;
    logic                journal_pending;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_W_ON,
    S_SEARCH,
    S_UPDATE,
    S_C_SCAN,
    S_R_RD,
    S_R_ON,
    S_FINISH
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic    latch_in;
    logic    rd_jrnl;
    logic    load_jrnl;
    logic    load_desc;
    logic    mul_need;
    logic    mul_on;
    logic    ns_from_old;
    logic    clr_idx;
    logic    inc_idx;
    logic    search_step;
    logic    sweep_step;
    logic    sweep_free;
    logic    claim;
    logic    commit_start;
    logic    commit_len;
    logic    jrnl_rec;
    logic    jrnl_clr;
    logic    res_load;
    status_e res_status;
    logic    res_use_idx;
    logic    res_use_ns;
    logic    out_load;
  } jcba_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    action_e act;
    logic    crash_hold;
    logic    crash_free;
    logic    crash_move;
    logic    d_bad;
    logic    d_unused;
    logic    jrnl_ok;
    logic    grows;
    logic    blk_last;
    logic    desc_last;
    logic    run_hit;
    logic    desc_free;
    logic    out_free;
  } jcba_sts_t;

endpackage

### hw/rtl/journaled_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// journaled_contiguous_block_allocator
// First-fit contiguous block allocator with a file table and a one-entry
// write journal. One transaction in, one result transaction out. A write
// runs a first-fit scan of the free map, one block per cycle (only when the
// file grows), then a mark/free sweep over all NUM_BLOCKS_P blocks, one per
// cycle. A repair runs the same sweep, a create a scan of the descriptor
// table. Items are handled one at a time; the result register lets the next
// transaction start while a result waits to be taken. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module journaled_contiguous_block_allocator import jcba_pkg::*; #(
  parameter int NUM_BLOCKS_P    = 64,
  parameter int BLOCK_BYTES     = 64,
  parameter int NUM_DESCRIPTORS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Command and status between the sequencer and the datapath
  jcba_cmd_t cmd;
  jcba_sts_t sts;

  // Sequencer: one state per phase of a transaction
  jcba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: free map, descriptor table, journal and result register.
  // Block counts come from a single shared reciprocal multiplier.
  jcba_dpath #(
    .NUM_BLOCKS_P    (NUM_BLOCKS_P),
    .BLOCK_BYTES     (BLOCK_BYTES),
    .NUM_DESCRIPTORS (NUM_DESCRIPTORS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted transaction always keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again right after a transaction");

  // Failed transactions never report a start block
  a_err_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_OK)) |-> (out_item_o.start_block == '0))
    else $error("error result carries a start block");

  // A claimed descriptor is only reported with a successful status
  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.created_descriptor != '0))
      |-> (out_item_o.status == ST_OK))
    else $error("created descriptor with a failing status");

endmodule

### hw/rtl/jcba_dpath.sv
// ----------------------------------------------------------------------------
// jcba_dpath
// Free map, descriptor table, journal, block-count unit and result register.
// ----------------------------------------------------------------------------
module jcba_dpath import jcba_pkg::*; #(
  parameter int NUM_BLOCKS_P    = 64,
  parameter int BLOCK_BYTES     = 64,
  parameter int NUM_DESCRIPTORS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  jcba_cmd_t cmd_i,
  output jcba_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int BW      = $clog2(NUM_BLOCKS_P);
  localparam int NBW     = $clog2(NUM_BLOCKS_P + 1);
  localparam int DW      = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
  localparam int MAX_CNT = (NUM_BLOCKS_P > NUM_DESCRIPTORS) ? NUM_BLOCKS_P : NUM_DESCRIPTORS;
  localparam int CW      = $clog2(MAX_CNT);
  // ceil(len / BLOCK_BYTES) by reciprocal multiply, exact for 14-bit operands
  localparam int MX_W      = LEN_W + 1;
  localparam int BLK_SHIFT = MX_W + $clog2(BLOCK_BYTES);
  localparam int BLK_RECIP = ((1 << BLK_SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int RCP_W     = MX_W + 1;
  localparam int PROD_W    = MX_W + RCP_W;
  localparam int MEM_W     = BW + LEN_W;

  // latched transaction
  action_e            act_q;
  logic [DESC_W-1:0]  d_q;
  logic [LEN_W-1:0]   len_q;
  logic [2:0]         crash_q;

  // working registers
  logic [BW-1:0]      os_q, ns_q;
  logic [LEN_W-1:0]   olen_q, need_q, on_q;
  logic               ohas_q;
  logic [CW-1:0]      idx_q;
  logic [NBW-1:0]     run_q;

  // state
  logic [NUM_BLOCKS_P-1:0]    used_q;
  logic [NUM_DESCRIPTORS-1:0] in_use_q, has_q;
  logic [MEM_W-1:0]           desc_mem [NUM_DESCRIPTORS];
  logic [MEM_W-1:0]           rd_q;
  logic                       jvalid_q;
  logic [DESC_W-1:0]          jdesc_q;
  logic [BW-1:0]              jstart_q;
  logic [LEN_W-1:0]           jlen_q;

  // result
  status_e             res_status_q;
  logic [DESC_W-1:0]   res_created_q;
  logic [START_W-1:0]  res_start_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic [DW-1:0]      d_idx, didx, raddr, waddr;
  logic [BW-1:0]      blk;
  logic               in_old, in_new, blk_free;
  logic [NBW-1:0]     run_n;
  logic [BW-1:0]      ns_hit;
  logic [LEN_W-1:0]   mul_op, mul_res;
  logic [MX_W-1:0]    mul_x;
  logic [PROD_W-1:0]  prod;
  logic               mem_we;
  logic [MEM_W-1:0]   mem_wd;

  assign d_idx = DW'(d_q);
  assign didx  = idx_q[DW-1:0];
  assign blk   = idx_q[BW-1:0];

  assign in_old   = (blk >= os_q) && (LEN_W'(blk - os_q) < on_q);
  assign in_new   = (blk >= ns_q) && (LEN_W'(blk - ns_q) < need_q);
  assign blk_free = !used_q[blk] || in_old;
  assign run_n    = blk_free ? (run_q + NBW'(1)) : '0;
  // on a hit the run length equals the block count
  assign ns_hit   = BW'(NBW'(blk) + NBW'(1) - run_n);

  assign mul_op  = cmd_i.mul_on ? olen_q : len_q;
  assign mul_x   = MX_W'(mul_op) + MX_W'(BLOCK_BYTES - 1);
  assign prod    = PROD_W'(mul_x) * PROD_W'(BLK_RECIP);
  assign mul_res = LEN_W'(prod >> BLK_SHIFT);

  assign raddr  = cmd_i.rd_jrnl ? DW'(jdesc_q) : DW'(in_item_i.descriptor);
  assign waddr  = cmd_i.claim ? didx : d_idx;
  assign mem_we = cmd_i.claim || cmd_i.commit_start;
  assign mem_wd = cmd_i.claim ? '0 : {ns_q, (cmd_i.commit_len ? len_q : olen_q)};

  always_comb begin
    sts_o            = '0;
    sts_o.act        = act_q;
    sts_o.crash_hold = (crash_q == CRASH_AFTER_JRNL) || (crash_q == CRASH_AFTER_JRNL_ALT);
    sts_o.crash_free = (crash_q == CRASH_AFTER_FREE);
    sts_o.crash_move = (crash_q == CRASH_AFTER_MOVE);
    sts_o.d_bad      = 32'(d_q) >= 32'(NUM_DESCRIPTORS);
    sts_o.d_unused   = !in_use_q[d_idx];
    sts_o.jrnl_ok    = jvalid_q && (32'(jdesc_q) < 32'(NUM_DESCRIPTORS));
    sts_o.grows      = len_q > olen_q;
    sts_o.blk_last   = idx_q == CW'(NUM_BLOCKS_P - 1);
    sts_o.desc_last  = idx_q == CW'(NUM_DESCRIPTORS - 1);
    sts_o.run_hit    = LEN_W'(run_n) == need_q;
    sts_o.desc_free  = !in_use_q[didx];
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // descriptor start/length store; entries are written by create before any read of them is used
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      desc_mem[waddr] <= mem_wd;
    end
    rd_q <= desc_mem[raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      in_use_q    <= '0;
      has_q       <= '0;
      jvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep_step) begin
        if (in_new) begin
          used_q[blk] <= 1'b1;
        end else if (in_old && cmd_i.sweep_free) begin
          used_q[blk] <= 1'b0;
        end
      end
      if (cmd_i.claim) begin
        in_use_q[didx] <= 1'b1;
        has_q[didx]    <= 1'b0;
      end else if (cmd_i.commit_start && (need_q != '0)) begin
        has_q[d_idx] <= 1'b1;
      end
      if (cmd_i.jrnl_clr) begin
        jvalid_q <= 1'b0;
      end else if (cmd_i.jrnl_rec) begin
        jvalid_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q   <= in_item_i.action;
      d_q     <= in_item_i.descriptor;
      len_q   <= in_item_i.byte_length;
      crash_q <= in_item_i.crash_stage;
    end else if (cmd_i.load_jrnl) begin
      d_q   <= jdesc_q;
      len_q <= jlen_q;
    end

    if (cmd_i.load_desc) begin
      {os_q, olen_q} <= rd_q;
      ohas_q         <= has_q[d_idx];
    end
    if (cmd_i.mul_need) begin
      need_q <= mul_res;
    end
    if (cmd_i.mul_on) begin
      on_q <= ohas_q ? mul_res : '0;
    end

    if (cmd_i.load_jrnl) begin
      ns_q <= jstart_q;
    end else if (cmd_i.ns_from_old) begin
      ns_q <= os_q;
    end else if (cmd_i.search_step && sts_o.run_hit) begin
      ns_q <= ns_hit;
    end

    if (cmd_i.clr_idx) begin
      idx_q <= '0;
      run_q <= '0;
    end else begin
      if (cmd_i.inc_idx) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.search_step) begin
        run_q <= run_n;
      end
    end

    if (cmd_i.jrnl_rec) begin
      jdesc_q  <= d_q;
      jstart_q <= ns_q;
      jlen_q   <= len_q;
    end

    if (cmd_i.res_load) begin
      res_status_q  <= cmd_i.res_status;
      res_created_q <= cmd_i.res_use_idx ? DESC_W'(didx) : '0;
      res_start_q   <= cmd_i.res_use_ns ? START_W'(ns_q) : '0;
    end

    if (cmd_i.out_load) begin
      out_item_q.status             <= res_status_q;
      out_item_q.created_descriptor <= res_created_q;
      out_item_q.start_block        <= res_start_q;
      out_item_q.journal_pending    <= jvalid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hw/rtl/jcba_ctrl.sv
// ----------------------------------------------------------------------------
// jcba_ctrl
// Sequencer for create, write and repair transactions.
// ----------------------------------------------------------------------------
module jcba_ctrl import jcba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  jcba_sts_t sts_i,
  output jcba_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   is_rep, start_en, len_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign is_rep   = sts_i.act == ACT_REPAIR;
  // crash points cut the write short
  assign start_en = is_rep || (!sts_i.crash_hold && !sts_i.crash_free);
  assign len_en   = is_rep || (start_en && !sts_i.crash_move);

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.act)
          ACT_CREATE: begin
            cmd_o.clr_idx = 1'b1;
            state_d       = S_C_SCAN;
          end
          ACT_WRITE: begin
            if (sts_i.d_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_BAD_DESC;
              state_d          = S_FINISH;
            end else if (sts_i.d_unused) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_UNUSED;
              state_d          = S_FINISH;
            end else begin
              cmd_o.load_desc = 1'b1;
              cmd_o.mul_need  = 1'b1;
              state_d         = S_W_ON;
            end
          end
          ACT_REPAIR: begin
            if (sts_i.jrnl_ok) begin
              cmd_o.load_jrnl = 1'b1;
              cmd_o.rd_jrnl   = 1'b1;
              state_d         = S_R_RD;
            end else begin
              cmd_o.jrnl_clr   = 1'b1;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_OK;
              state_d          = S_FINISH;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_OK;
            state_d          = S_FINISH;
          end
        endcase
      end
      S_W_ON: begin
        cmd_o.mul_on      = 1'b1;
        cmd_o.ns_from_old = 1'b1;
        cmd_o.clr_idx     = 1'b1;
        state_d           = sts_i.grows ? S_SEARCH : S_UPDATE;
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.run_hit) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = S_UPDATE;
        end else if (sts_i.blk_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_FINISH;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_free = is_rep || !sts_i.crash_hold;
        if (sts_i.blk_last) begin
          cmd_o.commit_start = start_en;
          cmd_o.commit_len   = len_en;
          cmd_o.jrnl_rec     = !is_rep;
          cmd_o.jrnl_clr     = len_en;
          cmd_o.res_load     = 1'b1;
          cmd_o.res_status   = ST_OK;
          cmd_o.res_use_ns   = 1'b1;
          state_d            = S_FINISH;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_C_SCAN: begin
        if (sts_i.desc_free) begin
          cmd_o.claim       = 1'b1;
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_OK;
          cmd_o.res_use_idx = 1'b1;
          state_d           = S_FINISH;
        end else if (sts_i.desc_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_DESC;
          state_d          = S_FINISH;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_R_RD: begin
        cmd_o.load_desc = 1'b1;
        cmd_o.mul_need  = 1'b1;
        state_d         = S_R_ON;
      end
      S_R_ON: begin
        cmd_o.mul_on  = 1'b1;
        cmd_o.clr_idx = 1'b1;
        state_d       = S_UPDATE;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for journaled_contiguous_block_allocator. A shadow copy of the
// free map, file table and journal computes the reply to every accepted
// request. Each reply is compared field by field against the oldest pending
// one. A short directed sequence opens the run; random traffic with random
// gaps and stalls on both channels follows.
// ----------------------------------------------------------------------------
module tb_top;
  import jcba_pkg::*;

  localparam int NBLK        = 64;
  localparam int BLK_BYTES   = 64;
  localparam int NDESC       = 16;
  localparam int N_RANDOM    = 650;
  localparam int TAIL_CYCLES = 2 * NBLK + 40;
  localparam int CYCLE_LIMIT = 1000000;

  // Shadow of the allocator: free map, file table, journal, pending replies
  class alloc_shadow;
    bit          blk_used [NBLK];
    bit          in_use   [NDESC];
    bit          has_blk  [NDESC];
    int unsigned start_of [NDESC];
    int unsigned len_of   [NDESC];
    bit          jv;
    int unsigned jd, js, jl;
    out_item_t   due_replies [$];
    int          errors;

    function int unsigned blocks_for(int unsigned len);
      return (len + BLK_BYTES - 1) / BLK_BYTES;
    endfunction

    function bit in_run(int unsigned i, int unsigned s, int unsigned n);
      return (i >= s) && ((i - s) < n);
    endfunction

    function void mark_run(int unsigned s, int unsigned n);
      for (int i = 0; i < NBLK; i++)
        if (in_run(i, s, n)) blk_used[i] = 1'b1;
    endfunction

    // free the file's blocks that fall outside its new run
    function void release_old(int unsigned d, int unsigned ns, int unsigned nn);
      int unsigned os, on;
      if (!has_blk[d]) return;
      os = start_of[d];
      on = blocks_for(len_of[d]);
      for (int i = 0; i < NBLK; i++)
        if (in_run(i, os, on) && !in_run(i, ns, nn)) blk_used[i] = 1'b0;
    endfunction

    function void set_start(int unsigned d, int unsigned s, int unsigned n);
      start_of[d] = s;
      if (n > 0) has_blk[d] = 1'b1;
    endfunction

    function out_item_t compute_reply(in_item_t it);
      out_item_t   r;
      int unsigned d, len, need, ns, os, on, run;
      bit          ok;
      r.status             = ST_OK;
      r.created_descriptor = '0;
      r.start_block        = '0;
      d   = it.descriptor;
      len = it.byte_length;
      case (it.action)
        ACT_CREATE: begin
          r.status = ST_NO_DESC;
          for (int i = 0; i < NDESC; i++) begin
            if (!in_use[i]) begin
              in_use[i]            = 1'b1;
              has_blk[i]           = 1'b0;
              start_of[i]          = 0;
              len_of[i]            = 0;
              r.created_descriptor = DESC_W'(i);
              r.status             = ST_OK;
              break;
            end
          end
        end
        ACT_WRITE: begin
          if (d >= NDESC) begin
            r.status = ST_BAD_DESC;
          end else if (!in_use[d]) begin
            r.status = ST_UNUSED;
          end else begin
            need = blocks_for(len);
            ns   = start_of[d];
            ok   = 1'b1;
            if (len > len_of[d]) begin
              // first fit; the file's own blocks count as free
              os  = start_of[d];
              on  = has_blk[d] ? blocks_for(len_of[d]) : 0;
              run = 0;
              ok  = 1'b0;
              for (int i = 0; i < NBLK; i++) begin
                if (!blk_used[i] || in_run(i, os, on)) run++;
                else run = 0;
                if (run == need) begin
                  ns = i + 1 - need;
                  ok = 1'b1;
                  break;
                end
              end
            end
            if (!ok) begin
              r.status = ST_NO_SPACE;
            end else begin
              r.start_block = START_W'(ns);
              mark_run(ns, need);
              jv = 1'b1;
              jd = d;
              js = ns;
              jl = len;
              if (it.crash_stage != CRASH_AFTER_JRNL &&
                  it.crash_stage != CRASH_AFTER_JRNL_ALT) begin
                release_old(d, ns, need);
                if (it.crash_stage != CRASH_AFTER_FREE) begin
                  set_start(d, ns, need);
                  if (it.crash_stage != CRASH_AFTER_MOVE) begin
                    len_of[d] = len;
                    jv        = 1'b0;
                  end
                end
              end
            end
          end
        end
        ACT_REPAIR: begin
          if (jv && jd < NDESC) begin
            need = blocks_for(jl);
            release_old(jd, js, need);
            set_start(jd, js, need);
            len_of[jd] = jl;
            mark_run(js, need);
            r.start_block = START_W'(js);
          end
          jv = 1'b0;
        end
        default: ;
      endcase
      r.journal_pending = jv;
      return r;
    endfunction

    function void note_request(in_item_t it);
      due_replies = {due_replies, compute_reply(it)};
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (due_replies.size() == 0) begin
        $error("unexpected result: status %0d start %0d", got.status, got.start_block);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.created_descriptor !== want.created_descriptor) begin
        $error("created_descriptor: expected %0d, actual %0d",
               want.created_descriptor, got.created_descriptor);
        errors++;
      end
      if (got.start_block !== want.start_block) begin
        $error("start_block: expected %0d, actual %0d", want.start_block, got.start_block);
        errors++;
      end
      if (got.journal_pending !== want.journal_pending) begin
        $error("journal_pending: expected %0d, actual %0d",
               want.journal_pending, got.journal_pending);
        errors++;
      end
    endfunction

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  alloc_shadow sb = new();
  bit          calm;        // no gaps or stalls while set
  int          n_made;      // files created so far (never freed)
  int          cycle_cnt;

  journaled_contiguous_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[journaled_contiguous_block_allocator] ERROR");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function in_item_t mk(action_e a, int d, int len, int crash);
    in_item_t it;
    it.action      = a;
    it.descriptor  = DESC_W'(d);
    it.byte_length = LEN_W'(len);
    it.crash_stage = 3'(crash);
    return it;
  endfunction

  function in_item_t random_request();
    in_item_t it;
    int       r;
    it.descriptor  = DESC_W'($urandom_range(0, NDESC - 1));
    it.crash_stage = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 10)      it.byte_length = '0;
    else if (r < 70) it.byte_length = LEN_W'($urandom_range(1, 640));
    else if (r < 90) it.byte_length = LEN_W'($urandom_range(641, 2048));
    else if (r < 97) it.byte_length = LEN_W'($urandom_range(2049, 4096));
    else             it.byte_length = LEN_W'($urandom_range(4097, 8191));
    r = $urandom_range(0, 99);
    if (r < 6)       it.action = ACT_CREATE;
    else if (r < 15) it.action = ACT_REPAIR;
    else if (r < 18) it.action = ACT_NOP;
    else begin
      it.action = ACT_WRITE;
      // most writes hit an open file and complete
      if (n_made > 0 && $urandom_range(0, 99) < 85)
        it.descriptor = DESC_W'($urandom_range(0, n_made - 1));
      if ($urandom_range(0, 99) < 70) it.crash_stage = '0;
    end
    return it;
  endfunction

  // Valid is lowered only when a gap follows, so it never drops and rises
  // within the same step.
  task push_request(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(it);
    if (it.action == ACT_CREATE && n_made < NDESC) n_made++;
  endtask

  task drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result channel: take a transaction when valid and not stalled, then
  // decide the stall for the next cycle.
  initial begin : result_side
    int hold;
    int g;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_reply(out_item_o);
      if (hold > 0) begin
        hold--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_stall_i <= 1'b1;
          hold = g - 1;
        end
      end
    end
  end

  initial begin : request_side
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    push_request(mk(ACT_WRITE, 3, 100, 0));    // file never created
    push_request(mk(ACT_REPAIR, 9, 77, 5));    // repair, journal empty
    push_request(mk(ACT_NOP, 15, 8191, 7));
    push_request(mk(ACT_CREATE, 0, 0, 0));
    push_request(mk(ACT_CREATE, 5, 4096, 3));
    push_request(mk(ACT_WRITE, 0, 0, 0));      // stays without blocks
    push_request(mk(ACT_WRITE, 0, 1, 0));
    push_request(mk(ACT_WRITE, 0, 4096, 0));   // whole map, own block free
    push_request(mk(ACT_WRITE, 1, 64, 0));     // map full
    push_request(mk(ACT_WRITE, 0, 8191, 0));   // more blocks than exist
    push_request(mk(ACT_WRITE, 0, 64, 0));     // shrink in place
    push_request(mk(ACT_WRITE, 1, 130, 1));    // crash after journal
    push_request(mk(ACT_WRITE, 1, 200, 2));    // journal overwritten
    push_request(mk(ACT_REPAIR, 0, 0, 0));
    push_request(mk(ACT_WRITE, 0, 500, 3));    // crash after freeing
    push_request(mk(ACT_REPAIR, 0, 0, 0));
    push_request(mk(ACT_WRITE, 0, 600, 0));    // grows over its own run
    push_request(mk(ACT_WRITE, 1, 700, 4));    // crash after moving start
    push_request(mk(ACT_NOP, 0, 0, 0));
    push_request(mk(ACT_REPAIR, 0, 0, 0));
    push_request(mk(ACT_WRITE, 1, 300, 7));    // high crash stage completes
    push_request(mk(ACT_WRITE, 0, 0, 6));
    push_request(mk(ACT_CREATE, 0, 0, 0));
    drain_requests();

    // random part, with two calm stretches and one full drain
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 150 && n < 210) || (n >= 480 && n < 530);
      if (n == 325) drain_requests();
      push_request(random_request());
    end
    calm = 1'b0;

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[journaled_contiguous_block_allocator] OK");
    else
      $display("[journaled_contiguous_block_allocator] ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/jcba_pkg.sv
hw/rtl/jcba_dpath.sv
hw/rtl/jcba_ctrl.sv
hw/rtl/journaled_contiguous_block_allocator.sv
verif/tb_top.sv
